FILE: sv/stereo_beat_repeat_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo beat repeat core
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_BEAT_REPEAT_CORE_MACROS_SVH
`define STEREO_BEAT_REPEAT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SBR_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SBR_ASSERT(label, prop, msg)
`define SBR_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

FILE: sv/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types, constants and helpers of the stereo beat repeat core.
// ----------------------------------------------------------------------------
package sbr_pkg;
    localparam int SW = 16;

    typedef logic signed [SW-1:0] t_smp;

    typedef enum logic [2:0] {
        CFG_ENABLE   = 3'd0,
        CFG_GATE     = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_CHANCE   = 3'd3,
        CFG_DECAY    = 3'd4,
        CFG_LOWPASS  = 3'd5,
        CFG_WET      = 3'd6,
        CFG_SEED     = 3'd7
    } t_cfg_idx;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic dec_en;
        logic lp_en;
        logic mp_en;
        logic use_rep;
        logic lp_on;
    } t_stage_ctl;

    function automatic t_smp sat19(input logic signed [18:0] x);
        if (x > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -19'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction
endpackage

FILE: sv/sbr_if.sv
// ----------------------------------------------------------------------------
// sbr_in_if / sbr_out_if
// Valid/ready channels for input frames and mixed result frames.
// ----------------------------------------------------------------------------
interface sbr_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      left_in;
    logic signed [15:0]      right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbr_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      left_out;
    logic signed [15:0]      right_out;
    logic                    is_repeating;
    modport source (output valid, output left_out, output right_out, output is_repeating,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input is_repeating,
                    output ready);
endinterface

FILE: sv/sbr_hist_mem.sv
// ----------------------------------------------------------------------------
// sbr_hist_mem
// Stereo history memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbr_hist_mem #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/sbr_chan.sv
// ----------------------------------------------------------------------------
// sbr_chan
// One channel of the wet path: decay, one-pole lowpass and dry/wet mix.
// ----------------------------------------------------------------------------
module sbr_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbr_pkg::t_stage_ctl i_ctl,
    input  sbr_pkg::t_smp       i_rep,
    input  sbr_pkg::t_smp       i_dry,
    input  logic [15:0]         i_decay,
    input  logic [15:0]         i_lpc,
    input  logic [15:0]         i_wet_mix,
    output sbr_pkg::t_smp       o_mix
);
    import sbr_pkg::*;

    t_smp                r_dec;
    t_smp                r_wet;
    t_smp                r_smooth;
    logic signed [33:0]  r_p1;
    logic signed [32:0]  r_p2;

    logic signed [32:0]  dec_prod;
    logic signed [16:0]  diff;
    logic signed [33:0]  lp_prod;
    logic signed [18:0]  lp_sum;
    t_smp                n_smooth;
    t_smp                n_wet;
    logic [16:0]         dry_gain;
    logic signed [34:0]  mix_sum;

    assign dec_prod = i_rep * $signed({1'b0, i_decay});
    assign diff     = {r_dec[15], r_dec} - {r_smooth[15], r_smooth};
    assign lp_prod  = diff * $signed({1'b0, i_lpc});
    assign lp_sum   = {{3{r_smooth[15]}}, r_smooth} + {lp_prod[33], lp_prod[33:16]};
    assign n_smooth = sat19(lp_sum);
    assign n_wet    = i_ctl.use_rep ? (i_ctl.lp_on ? n_smooth : r_dec) : i_dry;
    assign dry_gain = 17'h10000 - {1'b0, i_wet_mix};
    assign mix_sum  = {r_p1[33], r_p1} + {{2{r_p2[32]}}, r_p2};
    assign o_mix    = sat19(mix_sum[34:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
        end else if (i_ctl.lp_en && i_ctl.use_rep && i_ctl.lp_on) begin
            r_smooth <= n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dec_en) begin
            r_dec <= dec_prod[31:16];
        end
        if (i_ctl.lp_en) begin
            r_wet <= n_wet;
        end
        if (i_ctl.mp_en) begin
            r_p1 <= i_dry * $signed({1'b0, dry_gain});
            r_p2 <= r_wet * $signed({1'b0, i_wet_mix});
        end
    end
endmodule

FILE: sv/stereo_beat_repeat_core.sv
// ----------------------------------------------------------------------------
// stereo_beat_repeat_core
// Stereo beat repeat: circular history, random repeat trigger, decay,
// lowpass and dry/wet mix.
//
//   channel   dir   payload                                   handshake
//   i_in      in    left_in, right_in                         valid/ready
//   o_out     out   left_out, right_out, is_repeating         valid/ready
//   i_cfg_*   in    index 3b, data 32b                        write enable
//
// An item passes through history access, decay, lowpass, mix products and
// mix sum into the output register; the history memory port and the
// chained multiplies set these steps. One item is in work at a time.
// Reset is synchronous; the history needs no clearing pass (a fill flag
// masks entries not yet written). The final stage holds while o_out stalls.
// ----------------------------------------------------------------------------
`include "stereo_beat_repeat_core_macros.svh"

module stereo_beat_repeat_core #(
    parameter int HISTORY_DEPTH = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbr_in_if.sink      i_in,
    sbr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import sbr_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    function automatic logic [AW-1:0] gate_mod(input logic [16:0] g);
        logic [31:0] r;
        r = (g == 17'd0) ? 32'd1 : {15'd0, g};
        for (int k = 6; k >= 0; k--) begin
            if (r >= (32'(HISTORY_DEPTH) << k)) begin
                r = r - (32'(HISTORY_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_LP, S_MP, S_MS} t_state;

    logic        r_enable;
    logic [AW-1:0] r_gate;
    logic [23:0] r_ivl;
    logic [16:0] r_chance;
    logic [15:0] r_decay;
    logic [15:0] r_lpc;
    logic [15:0] r_wet;

    logic [AW-1:0] r_wp, r_pp;
    logic        r_full, r_rep_act;
    logic [23:0] r_cnt;
    logic [31:0] r_lfsr;

    t_state      r_state;
    t_smp        r_dry_l, r_dry_r;
    logic        r_was, r_fwd, r_rdv;
    logic        r_out_valid, r_out_rep;
    t_smp        r_out_l, r_out_r;

    logic        accept, proc;
    logic [AW-1:0] wp_next, pp_next;
    logic [AW:0] start_sum;
    logic [AW-1:0] start_pp;
    logic [23:0] cnt_inc, ivl_eff;
    logic [31:0] lfsr_next;
    logic        fire, hit;
    logic [31:0] rdata;
    t_smp        rep_l, rep_r, mix_l, mix_r;
    t_stage_ctl  ctl;
    logic        out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign proc     = accept && r_enable;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    assign wp_next   = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign pp_next   = (r_pp == LAST_IDX) ? '0 : r_pp + 1'b1;
    assign start_sum = {1'b0, wp_next} + (DEPTH_W - {1'b0, r_gate});
    assign start_pp  = (start_sum >= DEPTH_W) ? AW'(start_sum - DEPTH_W) : start_sum[AW-1:0];
    assign cnt_inc   = r_cnt + 24'd1;
    assign ivl_eff   = (r_ivl == 24'd0) ? 24'd1 : r_ivl;
    assign fire      = (cnt_inc >= ivl_eff);
    assign lfsr_next = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
    assign hit       = ({1'b0, lfsr_next[31:16]} < r_chance);

    sbr_hist_mem #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (proc),
        .i_waddr (r_wp),
        .i_wdata ({i_in.left_in, i_in.right_in}),
        .i_re    (proc),
        .i_raddr (r_pp),
        .o_rdata (rdata)
    );

    always_comb begin
        rep_l = '0;
        rep_r = '0;
        if (r_fwd) begin
            rep_l = r_dry_l;
            rep_r = r_dry_r;
        end else if (r_rdv) begin
            rep_l = rdata[31:16];
            rep_r = rdata[15:0];
        end
    end

    assign ctl.dec_en  = (r_state == S_DEC);
    assign ctl.lp_en   = (r_state == S_LP);
    assign ctl.mp_en   = (r_state == S_MP);
    assign ctl.use_rep = r_was;
    assign ctl.lp_on   = (r_lpc != 16'd0);

    sbr_chan u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_rep(rep_l), .i_dry(r_dry_l),
        .i_decay(r_decay), .i_lpc(r_lpc), .i_wet_mix(r_wet), .o_mix(mix_l)
    );

    sbr_chan u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_rep(rep_r), .i_dry(r_dry_r),
        .i_decay(r_decay), .i_lpc(r_lpc), .i_wet_mix(r_wet), .o_mix(mix_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_gate    <= gate_mod(17'd4800);
            r_ivl     <= 24'd24000;
            r_chance  <= 17'd32768;
            r_decay   <= 16'hFFFF;
            r_lpc     <= 16'd0;
            r_wet     <= 16'h8000;
            r_lfsr    <= 32'd44257;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:   r_enable <= i_cfg_wdata[0];
                CFG_GATE:     r_gate   <= gate_mod(i_cfg_wdata[16:0]);
                CFG_INTERVAL: r_ivl    <= i_cfg_wdata[23:0];
                CFG_CHANCE:   r_chance <= i_cfg_wdata[16:0];
                CFG_DECAY:    r_decay  <= i_cfg_wdata[15:0];
                CFG_LOWPASS:  r_lpc    <= i_cfg_wdata[15:0];
                CFG_WET:      r_wet    <= i_cfg_wdata[15:0];
                CFG_SEED:     r_lfsr   <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
                default: ;
            endcase
        end else if (proc && fire) begin
            r_lfsr <= lfsr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_pp      <= '0;
            r_full    <= 1'b0;
            r_rep_act <= 1'b0;
            r_cnt     <= '0;
        end else if (proc) begin
            r_wp <= wp_next;
            if (r_wp == LAST_IDX) begin
                r_full <= 1'b1;
            end
            if (fire) begin
                r_cnt     <= '0;
                r_rep_act <= hit;
                if (hit) begin
                    r_pp <= start_pp;
                end else if (r_rep_act) begin
                    r_pp <= pp_next;
                end
            end else begin
                r_cnt <= cnt_inc;
                if (r_rep_act) begin
                    r_pp <= pp_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_MS && out_free) begin
                r_out_valid <= 1'b1;
                r_out_l     <= mix_l;
                r_out_r     <= mix_r;
                r_out_rep   <= r_was;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: r_state <= S_LP;
                S_LP:  r_state <= S_MP;
                S_MP:  r_state <= S_MS;
                S_MS: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dry_l <= i_in.left_in;
            r_dry_r <= i_in.right_in;
            r_was   <= r_enable && r_rep_act;
            r_fwd   <= (r_pp == r_wp);
            r_rdv   <= r_full || (r_pp <= r_wp);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_out     = r_out_l;
    assign o_out.right_out    = r_out_r;
    assign o_out.is_repeating = r_out_rep;

    `SBR_ASSERT(a_wp_range, {1'b0, r_wp} < DEPTH_W, "write pointer out of range")
    `SBR_ASSERT(a_pp_range, {1'b0, r_pp} < DEPTH_W, "play pointer out of range")
    `SBR_ASSERT_IMPL(a_accept_seq, accept, r_state == S_DEC, "accepted item not started")
    `SBR_ASSERT_IMPL(a_out_hold, r_out_valid && !o_out.ready,
                     r_out_valid && $stable(r_out_l) && $stable(r_out_r), "result overwritten")
endmodule

FILE: dv/stereo_beat_repeat_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_beat_repeat_core_tb
// Self-checking bench for the stereo beat repeat core. A scoreboard class
// predicts every output frame from the accepted input frames and the
// register settings. Input bursts and output stalls are random. The run
// walks through many register settings, extremes among them.
// ----------------------------------------------------------------------------
module stereo_beat_repeat_core_tb;
    import sbr_pkg::*;

    localparam int DEPTH = 131072;

    typedef struct {
        t_smp left;
        t_smp right;
        logic rep;
    } t_frame_exp;

    class beat_repeat_scoreboard;
        bit [31:0]   enable, gate, interval, chance, decay, lp_coeff, wet, seed;
        int          hist_l[DEPTH];
        int          hist_r[DEPTH];
        int unsigned wr_ptr, play_ptr, ivl_cnt;
        bit          rep_on;
        longint      smooth_l, smooth_r;
        bit [31:0]   lfsr;
        t_frame_exp  exp_q[$];
        int          errors;
        int          n_in, n_out, n_rep;

        function new();
            enable = 0; gate = 4800; interval = 24000; chance = 32768;
            decay = 65535; lp_coeff = 0; wet = 32768; seed = 44257;
            foreach (hist_l[i]) begin
                hist_l[i] = 0;
                hist_r[i] = 0;
            end
            wr_ptr = 0; play_ptr = 0; ivl_cnt = 0; rep_on = 0;
            smooth_l = 0; smooth_r = 0; lfsr = seed;
            errors = 0; n_in = 0; n_out = 0; n_rep = 0;
        endfunction

        function longint clip(longint x);
            if (x > 32767) return 32767;
            if (x < -32768) return -32768;
            return x;
        endfunction

        function void write_cfg(t_cfg_idx idx, bit [31:0] val);
            case (idx)
                CFG_ENABLE:   enable = val & 32'h1;
                CFG_GATE:     gate = val & 32'h1FFFF;
                CFG_INTERVAL: interval = val & 32'hFFFFFF;
                CFG_CHANCE:   chance = val & 32'h1FFFF;
                CFG_DECAY:    decay = val & 32'hFFFF;
                CFG_LOWPASS:  lp_coeff = val & 32'hFFFF;
                CFG_WET:      wet = val & 32'hFFFF;
                CFG_SEED: begin
                    seed = val;
                    lfsr = (val != 0) ? val : 32'd1;
                end
                default: ;
            endcase
        endfunction

        function longint wet_sample(longint rep, ref longint smooth);
            longint w;
            w = (rep * longint'(decay)) >>> 16;
            if (lp_coeff != 0) begin
                smooth = clip(smooth + ((longint'(lp_coeff) * (w - smooth)) >>> 16));
                w = smooth;
            end
            return w;
        endfunction

        function t_smp mix_out(longint dry, longint w);
            return t_smp'(clip((dry * (65536 - longint'(wet)) + w * longint'(wet)) >>> 16));
        endfunction

        function void note_input(t_smp l, t_smp r);
            t_frame_exp  e;
            longint      wl, wr;
            int unsigned g, ivl;
            bit          lsb;
            n_in++;
            if (enable == 0) begin
                e.left = l; e.right = r; e.rep = 0;
                exp_q.push_back(e);
                return;
            end
            hist_l[wr_ptr] = l;
            hist_r[wr_ptr] = r;
            wl = l; wr = r;
            e.rep = rep_on;
            if (rep_on) begin
                wl = wet_sample(hist_l[play_ptr], smooth_l);
                wr = wet_sample(hist_r[play_ptr], smooth_r);
                play_ptr = (play_ptr + 1) % DEPTH;
            end
            e.left = mix_out(l, wl);
            e.right = mix_out(r, wr);
            exp_q.push_back(e);
            wr_ptr = (wr_ptr + 1) % DEPTH;
            ivl_cnt = (ivl_cnt + 1) & 32'hFFFFFF;
            ivl = (interval != 0) ? interval : 1;
            if (ivl_cnt >= ivl) begin
                ivl_cnt = 0;
                lsb = lfsr[0];
                lfsr = lfsr >> 1;
                if (lsb) lfsr ^= LFSR_TAPS;
                if ({16'd0, lfsr[31:16]} < chance) begin
                    g = ((gate != 0) ? gate : 1) % DEPTH;
                    rep_on = 1;
                    play_ptr = (wr_ptr + DEPTH - g) % DEPTH;
                end else begin
                    rep_on = 0;
                end
            end
        endfunction

        function void check_result(t_smp l, t_smp r, logic rep);
            t_frame_exp e;
            n_out++;
            if (exp_q.size() == 0) begin
                $error("output frame with no frame pending");
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (rep) n_rep++;
            if (l !== e.left) begin
                $error("left_out: expected %0d, got %0d", e.left, l);
                errors++;
            end
            if (r !== e.right) begin
                $error("right_out: expected %0d, got %0d", e.right, r);
                errors++;
            end
            if (rep !== e.rep) begin
                $error("is_repeating: expected %0d, got %0d", e.rep, rep);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_wdata;
    int          stall_mode;

    sbr_in_if  in_ch();
    sbr_out_if out_ch();

    beat_repeat_scoreboard sb;

    stereo_beat_repeat_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.left_in, in_ch.right_in);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.left_out, out_ch.right_out, out_ch.is_repeating);
    end

    // receiver stall pattern, mode changes now and then
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= ($urandom_range(0, 7) != 0);
            default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic send_frame(input t_smp l, input t_smp r);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.left_in <= l;
        in_ch.right_in <= r;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_cfg(idx, val);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_smp rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return t_smp'($urandom_range(0, 15)) - 16'sd8;
            default: return t_smp'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] pick(bit [31:0] a, bit [31:0] b, bit [31:0] c,
                                       bit [31:0] r);
        case ($urandom_range(0, 4))
            0: return a;
            1: return b;
            2: return c;
            default: return r;
        endcase
    endfunction

    initial begin
        t_smp dl[$];
        sb = new();
        stall_mode = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = 3'd0;
        cfg_wdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.left_in = '0;
        in_ch.right_in = '0;
        out_ch.ready = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: pass-through
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd0, -16'sd1);
        drain();

        // always-trigger, zero gate and zero interval, zero seed
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_GATE, 32'd0);
        write_reg(CFG_INTERVAL, 32'd0);
        write_reg(CFG_CHANCE, 32'd65536);
        write_reg(CFG_SEED, 32'd0);
        dl = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF, 16'sh8000, 16'sd5};
        foreach (dl[i]) send_frame(dl[i], ~dl[i]);
        drain();

        // full decay, full wet, heavy lowpass, gate beyond written data
        write_reg(CFG_DECAY, 32'd65535);
        write_reg(CFG_WET, 32'd65535);
        write_reg(CFG_LOWPASS, 32'd65535);
        write_reg(CFG_GATE, 32'd131071);
        write_reg(CFG_INTERVAL, 32'd2);
        foreach (dl[i]) send_frame(dl[i], dl[i]);
        drain();

        // chance zero never triggers; all-ones seed
        write_reg(CFG_CHANCE, 32'd0);
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        write_reg(CFG_DECAY, 32'd0);
        write_reg(CFG_WET, 32'd0);
        repeat (4) send_frame(16'sh8000, 16'sh7FFF);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
            write_reg(CFG_GATE, pick(0, 1, 131071, $urandom_range(1, 120)));
            write_reg(CFG_INTERVAL, (ph == 7) ? 32'hFFFFFF : pick(0, 1, 3, $urandom_range(1, 40)));
            write_reg(CFG_CHANCE, pick(0, 65536, 131071, $urandom_range(0, 65536)));
            write_reg(CFG_DECAY, pick(0, 65535, 32768, $urandom_range(0, 65535)));
            write_reg(CFG_LOWPASS, pick(0, 0, 65535, $urandom_range(0, 65535)));
            write_reg(CFG_WET, pick(0, 65535, 32768, $urandom_range(0, 65535)));
            if ($urandom_range(0, 1) == 1) write_reg(CFG_SEED, pick(0, 32'hFFFF_FFFF, 1, $urandom));
            for (int n = 0; n < 140; n++) begin
                send_frame(rand_sample(), rand_sample());
                sender_gap();
            end
            drain();
        end

        $display("Covered %0d input frames, %0d output frames, %0d of them repeated.",
                 sb.n_in, sb.n_out, sb.n_rep);
        $display("Settings swept: disabled, zero/max gate, interval, chance, gains, seed.");
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/sbr_pkg.sv
sv/sbr_if.sv
sv/sbr_hist_mem.sv
sv/sbr_chan.sv
sv/stereo_beat_repeat_core.sv
dv/stereo_beat_repeat_core_tb.sv
